// ===== src/piecewise_linear_lookup_table_unit_defines.svh =====
// Assertion macros shared by the piecewise-linear lookup table unit.
`ifndef PIECEWISE_LINEAR_LOOKUP_TABLE_UNIT_DEFINES_SVH
`define PIECEWISE_LINEAR_LOOKUP_TABLE_UNIT_DEFINES_SVH

// Asserts that the antecedent implies the consequent in the same cycle.
`define PLL_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Asserts that the antecedent implies the consequent in the following cycle.
`define PLL_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/pllt_pkg.sv =====
// Package with the widths, codes and request type of the lookup table unit.
package pllt_pkg;
    localparam int unsigned MaxPointsDefault = 64;
    localparam int unsigned FracBitsDefault  = 16;
    localparam int unsigned ValW   = 32;
    localparam int unsigned CountW = 7;
    localparam int unsigned StatW  = 2;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    localparam logic [StatW-1:0] STAT_OK    = 2'd0;
    localparam logic [StatW-1:0] STAT_FULL  = 2'd1;
    localparam logic [StatW-1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic            func;
        logic [ValW-1:0] key_x;
        logic [ValW-1:0] value_y;
    } req_t;
endpackage

// ===== src/pllt_ram.sv =====
// Generic single-port RAM with a registered read.
module pllt_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== src/pllt_queue.sv =====
// Two-entry request queue between the front and the back part.
module pllt_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  pllt_pkg::req_t  in_req,
    output logic            out_valid,
    input  logic            out_ready,
    output pllt_pkg::req_t  out_req
);
    pllt_pkg::req_t slot_reg [2];
    logic           rd_ptr_reg, wr_ptr_reg;
    logic [1:0]     cnt_reg;
    logic           push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_req   = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_req;
        end
        if (!aresetn) begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// ===== src/pllt_front.sv =====
// Front part: input skid register that accepts requests into the queue.
module pllt_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [pllt_pkg::ValW*2-1:0]   s_tdata,
    input  logic                          s_tuser,
    output logic                          q_valid,
    input  logic                          q_ready,
    output pllt_pkg::req_t                q_req
);
    logic           full_reg;
    pllt_pkg::req_t req_reg;

    assign s_tready = !full_reg || q_ready;
    assign q_valid  = full_reg;
    assign q_req    = req_reg;

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            req_reg.func    <= s_tuser;
            req_reg.key_x   <= s_tdata[pllt_pkg::ValW-1:0];
            req_reg.value_y <= s_tdata[pllt_pkg::ValW*2-1:pllt_pkg::ValW];
        end
        if (!aresetn) begin
            full_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            full_reg <= 1'b1;
        end else if (q_ready) begin
            full_reg <= 1'b0;
        end
    end
endmodule

// ===== src/pllt_back.sv =====
// Back part: sorted table walk, insert shift and serial divide.
module pllt_back #(
    parameter int unsigned MAX_POINTS = pllt_pkg::MaxPointsDefault
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              q_valid,
    output logic                              q_ready,
    input  pllt_pkg::req_t                    q_req,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [pllt_pkg::ValW-1:0]         m_tdata,
    output logic [pllt_pkg::StatW+pllt_pkg::CountW-1:0] m_tuser
);
    localparam int unsigned AW = $clog2(MAX_POINTS);
    localparam int unsigned NW = $clog2(MAX_POINTS + 1);
    localparam int unsigned VW = pllt_pkg::ValW;
    localparam int unsigned PW = 2 * VW + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN_RD, S_SCAN, S_SHIFT_RD, S_SHIFT_WR, S_PUT,
        S_QX1, S_QY0, S_QY1, S_QWAIT, S_MUL, S_DIV, S_DONE, S_OUT
    } state_t;

    state_t          state_reg;
    pllt_pkg::req_t  req_reg;
    logic [NW-1:0]   n_reg, idx_reg;
    logic [VW-1:0]   x0_reg, x1_reg, y0_reg, y1_reg;
    logic [VW-1:0]   res_reg;
    logic [pllt_pkg::StatW-1:0] stat_reg;
    logic [PW-1:0]   rem_reg;
    logic [2*VW-1:0] quo_reg;
    logic [6:0]      bit_reg;
    logic [VW:0]     num_reg, den_reg, mag_reg;
    logic            neg_reg;
    logic            outv_reg;

    logic            we;
    logic [AW-1:0]   addr;
    logic [VW-1:0]   wx, wy, rx, ry;
    logic [PW-1:0]   trial;

    pllt_ram #(.WIDTH(VW), .DEPTH(MAX_POINTS)) u_ram_x (
        .aclk(aclk), .we(we), .addr(addr), .wdata(wx), .rdata(rx));
    pllt_ram #(.WIDTH(VW), .DEPTH(MAX_POINTS)) u_ram_y (
        .aclk(aclk), .we(we), .addr(addr), .wdata(wy), .rdata(ry));

    assign q_ready  = (state_reg == S_IDLE) && !outv_reg;
    assign m_tvalid = outv_reg;
    assign m_tdata  = res_reg;
    assign m_tuser  = {pllt_pkg::CountW'(n_reg), stat_reg};

    assign trial = {rem_reg[PW-2:0], quo_reg[2*VW-1]} - {{(PW-VW-1){1'b0}}, den_reg};

    always_comb begin
        we   = 1'b0;
        addr = idx_reg[AW-1:0];
        wx   = rx;
        wy   = ry;
        unique case (state_reg)
            S_SHIFT_RD: begin
                addr = AW'(idx_reg - NW'(1));
            end
            S_SHIFT_WR: begin
                we   = 1'b1;
            end
            S_PUT: begin
                we   = 1'b1;
                wx   = req_reg.key_x;
                wy   = req_reg.value_y;
            end
            S_QY1: begin
                addr = AW'(idx_reg + NW'(1));
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            n_reg     <= '0;
            outv_reg  <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                outv_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid && q_ready) begin
                        req_reg  <= q_req;
                        res_reg  <= '0;
                        stat_reg <= pllt_pkg::STAT_OK;
                        idx_reg  <= '0;
                        if (q_req.func == pllt_pkg::FUNC_INSERT) begin
                            if (n_reg == NW'(MAX_POINTS)) begin
                                stat_reg  <= pllt_pkg::STAT_FULL;
                                state_reg <= S_OUT;
                            end else if (n_reg == '0) begin
                                state_reg <= S_PUT;
                            end else begin
                                state_reg <= S_SCAN_RD;
                            end
                        end else if (n_reg == '0) begin
                            stat_reg  <= pllt_pkg::STAT_EMPTY;
                            state_reg <= S_OUT;
                        end else begin
                            state_reg <= S_SCAN_RD;
                        end
                    end
                end
                S_SCAN_RD: begin
                    state_reg <= S_SCAN;
                end
                S_SCAN: begin
                    if (req_reg.func == pllt_pkg::FUNC_INSERT) begin
                        if ($signed(rx) >= $signed(req_reg.key_x)) begin
                            idx_reg   <= n_reg;
                            x0_reg    <= {{(VW-NW){1'b0}}, idx_reg};
                            state_reg <= S_SHIFT_RD;
                        end else if (idx_reg + NW'(1) == n_reg) begin
                            idx_reg   <= n_reg;
                            state_reg <= S_PUT;
                        end else begin
                            idx_reg   <= idx_reg + NW'(1);
                            state_reg <= S_SCAN_RD;
                        end
                    end else begin
                        if ($signed(rx) > $signed(req_reg.key_x)) begin
                            if (idx_reg == '0) begin
                                state_reg <= S_QY0;
                            end else begin
                                idx_reg   <= idx_reg - NW'(1);
                                state_reg <= S_QX1;
                            end
                        end else if (idx_reg + NW'(1) == n_reg) begin
                            state_reg <= S_QY0;
                        end else begin
                            idx_reg   <= idx_reg + NW'(1);
                            state_reg <= S_SCAN_RD;
                        end
                    end
                end
                S_SHIFT_RD: begin
                    if (idx_reg == x0_reg[NW-1:0]) begin
                        state_reg <= S_PUT;
                    end else begin
                        state_reg <= S_SHIFT_WR;
                    end
                end
                S_SHIFT_WR: begin
                    idx_reg   <= idx_reg - NW'(1);
                    state_reg <= S_SHIFT_RD;
                end
                S_PUT: begin
                    n_reg     <= n_reg + NW'(1);
                    state_reg <= S_OUT;
                end
                S_QY0: begin
                    state_reg <= S_DONE;
                end
                S_QX1: begin
                    state_reg <= S_QY1;
                end
                S_QY1: begin
                    x0_reg    <= rx;
                    y0_reg    <= ry;
                    state_reg <= S_QWAIT;
                end
                S_QWAIT: begin
                    x1_reg    <= rx;
                    y1_reg    <= ry;
                    bit_reg   <= '0;
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    if (bit_reg == 7'd0) begin
                        num_reg <= {req_reg.key_x[VW-1], req_reg.key_x}
                                   - {x0_reg[VW-1], x0_reg};
                        den_reg <= {x1_reg[VW-1], x1_reg} - {x0_reg[VW-1], x0_reg};
                        neg_reg <= $signed({y1_reg[VW-1], y1_reg})
                                   < $signed({y0_reg[VW-1], y0_reg});
                        mag_reg <= ($signed({y1_reg[VW-1], y1_reg})
                                    < $signed({y0_reg[VW-1], y0_reg}))
                                   ? ({y0_reg[VW-1], y0_reg} - {y1_reg[VW-1], y1_reg})
                                   : ({y1_reg[VW-1], y1_reg} - {y0_reg[VW-1], y0_reg});
                        bit_reg <= 7'd1;
                    end else begin
                        quo_reg   <= mag_reg[VW-1:0] * num_reg[VW-1:0];
                        rem_reg   <= '0;
                        bit_reg   <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (trial[PW-1]) begin
                        rem_reg <= {rem_reg[PW-2:0], quo_reg[2*VW-1]};
                        quo_reg <= {quo_reg[2*VW-2:0], 1'b0};
                    end else begin
                        rem_reg <= trial;
                        quo_reg <= {quo_reg[2*VW-2:0], 1'b1};
                    end
                    bit_reg <= bit_reg + 7'd1;
                    if (bit_reg == 7'(2 * VW)) begin
                        state_reg <= S_OUT;
                        res_reg   <= neg_reg
                            ? (y0_reg - quo_reg[VW-1:0])
                            : (y0_reg + quo_reg[VW-1:0]);
                    end
                end
                S_DONE: begin
                    res_reg   <= ry;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (!outv_reg || m_tready) begin
                        outv_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

// ===== src/piecewise_linear_lookup_table_unit.sv =====
// Top level of the piecewise-linear lookup table unit.
//  channel   dir  tdata              tuser
//  s_        in   key_x, value_y     func
//  m_        out  result_y           status, point_count
// An insert searches the points in order, then shifts each point not below its key up.
// A query scans the points, reads both breakpoints and divides; off the ends it clamps.
// Reset empties the table at once; stored entries stay undefined until written.
// The back part takes no new request until its result has been accepted.
// A queue lets the front accept while the back is busy or stalled.
`include "piecewise_linear_lookup_table_unit_defines.svh"
module piecewise_linear_lookup_table_unit #(
    parameter int unsigned MAX_POINTS = pllt_pkg::MaxPointsDefault
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // key_x, value_y
    input  logic         s_tuser,   // func
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,   // result_y
    output logic [8:0]   m_tuser    // status, point_count
);
    logic           f_valid, f_ready, b_valid, b_ready;
    pllt_pkg::req_t f_req, b_req;

    pllt_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .s_tuser(s_tuser), .q_valid(f_valid), .q_ready(f_ready),
        .q_req(f_req));

    pllt_queue u_queue (
        .aclk(aclk), .aresetn(aresetn), .in_valid(f_valid), .in_ready(f_ready),
        .in_req(f_req), .out_valid(b_valid), .out_ready(b_ready), .out_req(b_req));

    pllt_back #(.MAX_POINTS(MAX_POINTS)) u_back (
        .aclk(aclk), .aresetn(aresetn), .q_valid(b_valid), .q_ready(b_ready),
        .q_req(b_req), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser));

    `PLL_ASSERT_IMPL(a_err_zero, aclk, aresetn, m_tvalid && m_tuser[1:0] != pllt_pkg::STAT_OK, m_tdata == '0, "error result carries nonzero data")
    `PLL_ASSERT_IMPL(a_stat_code, aclk, aresetn, m_tvalid, m_tuser[1:0] != 2'd3, "undefined status code")
    `PLL_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")
endmodule
